// File: rtl/core/evsm_pkg.sv
// ----------------------------------------------------------------------------
// evsm_pkg
// Shared types and constants of the eight-voice sample mixer: request and
// result formats, request codes, sequencer states and arithmetic constants.
// ----------------------------------------------------------------------------
package evsm_pkg;

  // Default configuration
  localparam int VOICES_DEF    = 8;
  localparam int ADDR_BITS_DEF = 16;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_MIX   = 2'd2,
    REQ_NONE  = 2'd3
  } evsm_req_e;

  // Result kinds
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_MIX   = 1'b1
  } evsm_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_PICK,
    ST_GAIN,
    ST_FINISH,
    ST_MIX,
    ST_MIX_DRAIN
  } evsm_state_e;

  // Arithmetic constants
  localparam logic [15:0] HANDLE_FIRST = 16'd100;
  localparam logic [7:0]  SILENCE      = 8'd128;
  localparam logic [8:0]  SEP_SPAN     = 9'd256;   // 257 - (sep + 1)
  localparam logic [23:0] DIV_RECIP    = 24'd8454660; // floor(2^30 / 127)
  localparam int          RECIP_SHIFT  = 30;
  localparam int          SCALE_DIV    = 127;
  localparam int          SAT_MAX      = 32767;
  localparam int          SAT_MIN      = -32768;

  // One request
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [16:0] sound_length;
    logic [7:0]  sound_id;
    logic        exclusive;
    logic [3:0]  volume;
    logic [7:0]  separation;
    logic [17:0] pitch_step;
    logic [30:0] tick;
  } evsm_req_t;

  // One result
  typedef struct packed {
    logic               result_kind;
    logic [15:0]        handle;
    logic [2:0]         voice_slot;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } evsm_res_t;

endpackage

// File: rtl/core/evsm_ram.sv
// ----------------------------------------------------------------------------
// evsm_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module evsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/evsm_engine.sv
// ----------------------------------------------------------------------------
// evsm_engine
// Voice sequencer: holds the per-voice state in a voice RAM, walks it one
// entry a cycle to allocate or mix, and reads and writes the sample store.
// ----------------------------------------------------------------------------
module evsm_engine
  import evsm_pkg::*;
#(
  parameter int VOICES           = VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  evsm_req_t                   req_i,
  output logic                        res_valid_o,
  output evsm_res_t                   res_o,
  output logic                        store_we_o,
  output logic [SAMPLE_ADDR_BITS-1:0] store_waddr_o,
  output logic [7:0]                  store_wdata_o,
  output logic [SAMPLE_ADDR_BITS-1:0] store_raddr_o,
  input  logic [7:0]                  store_rdata_i
);

  localparam int AW   = SAMPLE_ADDR_BITS;
  localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VAW  = ((AW > 17) ? AW : 17) + 2;
  localparam int ACW  = ((VOICES > 1) ? $clog2(VOICES) : 0) + 17;
  localparam logic [VIW-1:0] LAST_IX = VIW'(VOICES - 1);
  localparam logic signed [ACW-1:0] SMAX = ACW'(SAT_MAX);
  localparam logic signed [ACW-1:0] SMIN = ACW'(SAT_MIN);

  typedef struct packed {
    logic [VAW-1:0] addr;
    logic [VAW-1:0] fin;
    logic [17:0]    step;
    logic [15:0]    frac;
    logic [30:0]    tick;
    logic [7:0]     id;
    logic [6:0]     gl;
    logic [6:0]     gr;
  } voice_t;

  localparam int VW = $bits(voice_t);

  evsm_state_e state_q, state_d;
  evsm_req_t   req_q;
  logic [VIW-1:0] ix_q, ix_d;
  logic [VOICES-1:0] act_q, act_d;
  logic           p1_q;
  logic [VIW-1:0] p1_ix_q;
  logic           killed_q, killed_d;
  logic [30:0]    old_tick_q, old_tick_d;
  logic [VIW-1:0] old_slot_q, old_slot_d;
  logic [VIW-1:0] slot_q;
  logic [15:0]    pl1_q, pr1_q;
  logic [24:0]    pl2_q, pr2_q;
  logic [15:0]    hc_q;
  evsm_res_t      res_q;
  logic           res_vld_q;

  // mix pipeline
  logic           s2_vld_q;
  logic [6:0]     s2_gl_q, s2_gr_q;
  logic           s3_vld_q, s3_neg_q;
  logic [13:0]    s3_pl_q, s3_pr_q;
  logic           s4_vld_q, s4_neg_q;
  logic [21:0]    s4_ml_q, s4_mr_q;
  logic [15:0]    s4_ql_q, s4_qr_q;
  logic signed [ACW-1:0] acc_l_q, acc_r_q;

  // voice RAM ports
  logic           vram_we;
  logic [VIW-1:0] vram_waddr, vram_raddr;
  voice_t         vram_wdata, vram_rdata;

  logic accept;
  logic is_mix;
  logic s1_live;

  evsm_ram #(
    .WIDTH(VW),
    .DEPTH(VOICES)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(vram_waddr),
    .wdata_i(vram_wdata),
    .raddr_i(vram_raddr),
    .rdata_o(vram_rdata)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign is_mix      = (req_q.req_type == REQ_MIX);
  assign s1_live     = p1_q && act_q[p1_ix_q];
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // store writes go straight through on acceptance
  assign store_we_o    = accept && (req_i.req_type == REQ_WRITE);
  assign store_waddr_o = AW'(req_i.mem_addr);
  assign store_wdata_o = req_i.mem_data;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.req_type == REQ_START) state_d = ST_SCAN;
        else if (accept && req_i.req_type == REQ_MIX) state_d = ST_MIX;
      end
      ST_SCAN:       if (ix_q == LAST_IX) state_d = ST_SCAN_DRAIN;
      ST_SCAN_DRAIN: if (!p1_q) state_d = ST_PICK;
      ST_PICK:       state_d = ST_GAIN;
      ST_GAIN:       state_d = ST_FINISH;
      ST_FINISH:     state_d = ST_IDLE;
      ST_MIX:        if (ix_q == LAST_IX) state_d = ST_MIX_DRAIN;
      ST_MIX_DRAIN: begin
        if (!p1_q && !s2_vld_q && !s3_vld_q && !s4_vld_q) state_d = ST_IDLE;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // voice slot choice: lowest free voice, else the oldest
  logic           any_free;
  logic [VIW-1:0] free_ix;
  always_comb begin
    any_free = 1'b0;
    free_ix  = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        any_free = 1'b1;
        free_ix  = VIW'(i);
      end
    end
  end

  // gain arithmetic operands
  logic [6:0] vol8;
  logic [8:0] sep_l, sep_r;
  assign vol8  = {req_q.volume, 3'b000};
  assign sep_l = {1'b0, req_q.separation} + 9'd1;
  assign sep_r = SEP_SPAN - {1'b0, req_q.separation};

  logic [8:0]  gl_full, gr_full;
  assign gl_full = {2'b00, vol8} - pl2_q[24:16];
  assign gr_full = {2'b00, vol8} - pr2_q[24:16];

  // voice advance for the entry at the read stage
  logic [18:0]    fsum;
  logic [VAW-1:0] naddr;
  voice_t         vnext;
  assign fsum  = {3'b000, vram_rdata.frac} + {1'b0, vram_rdata.step};
  assign naddr = vram_rdata.addr + VAW'(fsum[18:16]);
  always_comb begin
    vnext      = vram_rdata;
    vnext.addr = naddr;
    vnext.frac = fsum[15:0];
  end

  // new voice entry
  voice_t         vnew;
  logic [VAW-1:0] start_addr;
  assign start_addr = VAW'(AW'(req_q.mem_addr));
  always_comb begin
    vnew.addr = start_addr;
    vnew.fin  = start_addr + VAW'(req_q.sound_length);
    vnew.step = req_q.pitch_step;
    vnew.frac = '0;
    vnew.tick = req_q.tick;
    vnew.id   = req_q.sound_id;
    vnew.gl   = gl_full[6:0];
    vnew.gr   = gr_full[6:0];
  end

  // outputs of the sequencer: RAM ports, voice flags, scan bookkeeping
  always_comb begin
    vram_we       = 1'b0;
    vram_waddr    = p1_ix_q;
    vram_wdata    = vnext;
    vram_raddr    = ix_q;
    store_raddr_o = vram_rdata.addr[AW-1:0];
    act_d         = act_q;
    killed_d      = killed_q;
    old_tick_d    = old_tick_q;
    old_slot_d    = old_slot_q;
    ix_d          = ix_q;

    if (state_q == ST_SCAN || state_q == ST_MIX) begin
      ix_d = ix_q + VIW'(1);
    end

    // mix: write back the advanced voice and retire it at its end
    if (s1_live && is_mix) begin
      vram_we = 1'b1;
      if (naddr >= vram_rdata.fin) act_d[p1_ix_q] = 1'b0;
    end

    // allocation scan: exclusive stop and oldest search
    if (p1_q && !is_mix) begin
      if (req_q.exclusive && act_q[p1_ix_q] && !killed_q &&
          vram_rdata.id == req_q.sound_id) begin
        act_d[p1_ix_q] = 1'b0;
        killed_d       = 1'b1;
      end
      if (vram_rdata.tick < old_tick_q) begin
        old_tick_d = vram_rdata.tick;
        old_slot_d = p1_ix_q;
      end
    end

    // claim the chosen voice
    if (state_q == ST_FINISH) begin
      vram_we        = 1'b1;
      vram_waddr     = slot_q;
      vram_wdata     = vnew;
      act_d[slot_q]  = 1'b1;
    end

    if (accept) begin
      ix_d       = '0;
      killed_d   = 1'b0;
      old_tick_d = req_i.tick;
      old_slot_d = '0;
    end
  end

  // sample scaling: gain * |byte - 128| and its sign
  logic [7:0]  mag;
  logic        neg;
  assign neg = (store_rdata_i < SILENCE);
  assign mag = neg ? (SILENCE - store_rdata_i) : (store_rdata_i - SILENCE);

  // divide by 127: reciprocal product, then one correction step
  logic [45:0] prod_l, prod_r;
  assign prod_l = 46'({s3_pl_q, 8'h00}) * 46'(DIV_RECIP);
  assign prod_r = 46'({s3_pr_q, 8'h00}) * 46'(DIV_RECIP);

  logic [22:0] rem_l, rem_r;
  logic [15:0] q_l, q_r;
  logic signed [ACW-1:0] add_l, add_r;
  assign rem_l = {1'b0, s4_ml_q} - (23'({s4_ql_q, 7'b0}) - 23'(s4_ql_q));
  assign rem_r = {1'b0, s4_mr_q} - (23'({s4_qr_q, 7'b0}) - 23'(s4_qr_q));
  assign q_l   = s4_ql_q + 16'(rem_l >= 23'(SCALE_DIV));
  assign q_r   = s4_qr_q + 16'(rem_r >= 23'(SCALE_DIV));
  assign add_l = s4_neg_q ? -ACW'(q_l) : ACW'(q_l);
  assign add_r = s4_neg_q ? -ACW'(q_r) : ACW'(q_r);

  // saturate the frame sums
  logic signed [15:0] sat_l, sat_r;
  always_comb begin
    priority if (acc_l_q > SMAX) sat_l = 16'(SAT_MAX);
    else if (acc_l_q < SMIN)     sat_l = 16'(SAT_MIN);
    else                         sat_l = acc_l_q[15:0];
    priority if (acc_r_q > SMAX) sat_r = 16'(SAT_MAX);
    else if (acc_r_q < SMIN)     sat_r = 16'(SAT_MIN);
    else                         sat_r = acc_r_q[15:0];
  end

  logic [15:0] handle_use;
  assign handle_use = (hc_q == '0) ? HANDLE_FIRST : hc_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= '0;
      p1_q      <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      killed_q  <= 1'b0;
      hc_q      <= '0;
      res_vld_q <= 1'b0;
      ix_q      <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      ix_q      <= ix_d;
      killed_q  <= killed_d;
      p1_q      <= (state_q == ST_SCAN) || (state_q == ST_MIX);
      s2_vld_q  <= s1_live && is_mix;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      res_vld_q <= (state_q == ST_FINISH) ||
                   (state_q == ST_MIX_DRAIN && state_d == ST_IDLE);
      if (state_q == ST_FINISH) hc_q <= handle_use + 16'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    p1_ix_q    <= ix_q;
    old_tick_q <= old_tick_d;
    old_slot_q <= old_slot_d;

    // pick the slot and form the first gain products
    if (state_q == ST_PICK) begin
      slot_q <= any_free ? free_ix : old_slot_q;
      pl1_q  <= 16'(vol8) * 16'(sep_l);
      pr1_q  <= 16'(vol8) * 16'(sep_r);
    end
    if (state_q == ST_GAIN) begin
      pl2_q <= 25'(pl1_q) * 25'(sep_l);
      pr2_q <= 25'(pr1_q) * 25'(sep_r);
    end

    // mix pipeline stages
    s2_gl_q  <= vram_rdata.gl;
    s2_gr_q  <= vram_rdata.gr;
    s3_neg_q <= neg;
    s3_pl_q  <= 14'(s2_gl_q * 15'(mag));
    s3_pr_q  <= 14'(s2_gr_q * 15'(mag));
    s4_neg_q <= s3_neg_q;
    s4_ml_q  <= {s3_pl_q, 8'h00};
    s4_mr_q  <= {s3_pr_q, 8'h00};
    s4_ql_q  <= prod_l[RECIP_SHIFT+15:RECIP_SHIFT];
    s4_qr_q  <= prod_r[RECIP_SHIFT+15:RECIP_SHIFT];

    // accumulate the frame
    if (accept) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (s4_vld_q) begin
      acc_l_q <= acc_l_q + add_l;
      acc_r_q <= acc_r_q + add_r;
    end

    // form the result
    if (state_q == ST_FINISH) begin
      res_q.result_kind  <= KIND_START;
      res_q.handle       <= handle_use;
      res_q.voice_slot   <= 3'(slot_q);
      res_q.left_sample  <= '0;
      res_q.right_sample <= '0;
    end else if (state_q == ST_MIX_DRAIN) begin
      res_q.result_kind  <= KIND_MIX;
      res_q.handle       <= '0;
      res_q.voice_slot   <= '0;
      res_q.left_sample  <= sat_l;
      res_q.right_sample <= sat_r;
    end
  end

  // the voice RAM and the sample store are never written in the same cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vram_we && store_we_o))
    else $error("voice RAM and sample store written together");

  // a result follows a busy cycle
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q == ST_FINISH || state_q == ST_MIX_DRAIN))
    else $error("result strobe without a finishing request");

  // voice flags only change while a request is worked on
  a_act_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q == ST_IDLE)) |-> $stable(act_q))
    else $error("voice flags changed while idle");

  // a claimed voice is active afterward
  a_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> act_q[$past(slot_q)])
    else $error("claimed voice not active");

endmodule

// File: rtl/core/eight_voice_sample_mixer_top.sv
// ----------------------------------------------------------------------------
// eight_voice_sample_mixer_top
// Eight-voice mixer for unsigned 8-bit samples with a sample byte store.
//
//   channel   | ports                    | handshake
//   ----------+--------------------------+-------------------------------
//   request   | start_i, busy_o, req_i   | taken when start_i && !busy_o
//   result    | res_valid_o, res_o       | one-cycle strobe, no back-pressure
//
// A write request is passed straight to the sample store. A start request and
// a mix request each walk the voice RAM (one entry a cycle); a mix request also
// runs the scaling pipeline behind the walk before its result.
// Reset clears all voice flags and the handle counter; the sample store is
// not cleared and needs no clearing pass. The result cannot be stalled.
// ----------------------------------------------------------------------------
module eight_voice_sample_mixer_top
  import evsm_pkg::*;
#(
  parameter int VOICES           = VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  evsm_req_t req_i,
  output logic      res_valid_o,
  output evsm_res_t res_o
);

  localparam int STORE_DEPTH = 1 << SAMPLE_ADDR_BITS;

  logic                        store_we;
  logic [SAMPLE_ADDR_BITS-1:0] store_waddr, store_raddr;
  logic [7:0]                  store_wdata, store_rdata;

  // sample byte store
  evsm_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(store_waddr),
    .wdata_i(store_wdata),
    .raddr_i(store_raddr),
    .rdata_o(store_rdata)
  );

  // voice sequencer
  evsm_engine #(
    .VOICES          (VOICES),
    .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_i        (req_i),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o),
    .store_we_o   (store_we),
    .store_waddr_o(store_waddr),
    .store_wdata_o(store_wdata),
    .store_raddr_o(store_raddr),
    .store_rdata_i(store_rdata)
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-voice sample mixer: a queue-fed driver
// issues write, start and mix requests; an inline voice model predicts each
// start handle and mixed frame, and a monitor compares them field by field.
// ----------------------------------------------------------------------------
module tb
  import evsm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV        = 8;
  localparam int CYC_LIMIT = 2000000;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  evsm_req_t req_i;
  logic      res_valid_o;
  evsm_res_t res_o;

  eight_voice_sample_mixer_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // Voice model state
  logic [7:0]  store_q [bit [15:0]];
  logic        v_on    [NV];
  logic [18:0] v_addr  [NV];
  logic [18:0] v_end   [NV];
  logic [17:0] v_step  [NV];
  logic [15:0] v_frac  [NV];
  logic [30:0] v_tick  [NV];
  logic [7:0]  v_id    [NV];
  int          v_lg    [NV];
  int          v_rg    [NV];
  logic [15:0] handle_q;

  evsm_req_t pending_q[$];
  evsm_res_t expected_q[$];
  int        mismatches;
  int        idle_pct;
  int        cycles;
  logic      busy_q_taken;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int scaled(int g, logic [7:0] b);
    return (g * (int'(b) - 128) * 256) / 127;
  endfunction

  function automatic int sat16(int v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // Predict the result of one accepted request
  task automatic predict_request(evsm_req_t r);
    evsm_res_t   e;
    logic [30:0] oldest;
    int          oslot, i, slot, vv, s, dl, dr;
    logic [32:0] f;
    e = '0;
    case (r.req_type)
      REQ_WRITE: store_q[r.mem_addr] = r.mem_data;
      REQ_START: begin
        if (r.exclusive) begin
          for (i = 0; i < NV; i++) begin
            if (v_on[i] && v_id[i] == r.sound_id) begin
              v_on[i] = 1'b0;
              break;
            end
          end
        end
        oldest = r.tick;
        oslot = 0;
        for (i = 0; i < NV && v_on[i]; i++) begin
          if (v_tick[i] < oldest) begin
            oldest = v_tick[i];
            oslot = i;
          end
        end
        slot = (i == NV) ? oslot : i;
        v_on[slot] = 1'b1;
        v_addr[slot] = 19'(r.mem_addr);
        v_end[slot] = 19'(r.mem_addr) + 19'(r.sound_length);
        if (handle_q == 0) handle_q = HANDLE_FIRST;
        e.handle = handle_q;
        handle_q = handle_q + 16'd1;
        v_step[slot] = r.pitch_step;
        v_frac[slot] = '0;
        v_tick[slot] = r.tick;
        vv = int'(r.volume) * 8;
        s = int'(r.separation) + 1;
        v_lg[slot] = vv - ((vv * s * s) >>> 16);
        s = s - 257;
        v_rg[slot] = vv - ((vv * s * s) >>> 16);
        v_id[slot] = r.sound_id;
        e.result_kind = KIND_START;
        e.voice_slot = 3'(slot);
        expected_q.push_back(e);
      end
      REQ_MIX: begin
        dl = 0;
        dr = 0;
        for (i = 0; i < NV; i++) begin
          if (!v_on[i]) continue;
          dl += scaled(v_lg[i], store_q[v_addr[i][15:0]]);
          dr += scaled(v_rg[i], store_q[v_addr[i][15:0]]);
          f = {17'd0, v_frac[i]} + v_step[i];
          v_addr[i] = v_addr[i] + 19'(f[32:16]);
          v_frac[i] = f[15:0];
          if (v_addr[i] >= v_end[i]) v_on[i] = 1'b0;
        end
        e.result_kind = KIND_MIX;
        e.left_sample = 16'(sat16(dl));
        e.right_sample = 16'(sat16(dr));
        expected_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  // Driver: offer requests at the falling edge, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_q_taken) begin
        // hold current request
      end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_i <= pending_q.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Acceptance tracking and result checking at the rising edge
  initial busy_q_taken = 1'b0;
  always @(posedge clk_i) begin
    busy_q_taken <= 1'b0;
    if (rst_ni && start_i && !busy_o) begin
      predict_request(req_i);
      busy_q_taken <= 1'b1;
    end
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else if (res_o !== expected_q[0]) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", expected_q[0], res_o);
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
  end

  // Sound bank bookkeeping for stimulus: written byte ranges
  logic [15:0] bank_base [4];
  int          bank_len  [4];

  function automatic evsm_req_t blank_req();
    evsm_req_t r;
    r = '0;
    r.req_type = REQ_NONE;
    return r;
  endfunction

  function automatic evsm_req_t wr_req(logic [15:0] a, logic [7:0] d);
    evsm_req_t r;
    r = evsm_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_WRITE;
    r.mem_addr = a;
    r.mem_data = d;
    return r;
  endfunction

  function automatic evsm_req_t mix_req();
    evsm_req_t r;
    r = evsm_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_MIX;
    return r;
  endfunction

  // Start on bank b; length bounded so every read stays in written bytes
  function automatic evsm_req_t snd_req(int b, logic [30:0] t);
    evsm_req_t r;
    int        off;
    r = evsm_req_t'({$urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_START;
    off = $urandom_range(bank_len[b] - 1);
    r.mem_addr = bank_base[b] + 16'(off);
    r.sound_length = 17'($urandom_range(bank_len[b] - off));
    r.sound_id = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
    r.tick = t;
    // Step that cannot jump over the written range before the end check
    case ($urandom_range(3))
      0: r.pitch_step = 18'd0;
      1: r.pitch_step = 18'h10000;
      default: r.pitch_step = 18'($urandom_range(18'h10000));
    endcase
    return r;
  endfunction

  task automatic fill_bank(int b, logic [15:0] base, int n);
    bank_base[b] = base;
    bank_len[b] = n;
    for (int k = 0; k <= n; k++) pending_q.push_back(wr_req(base + 16'(k), 8'($urandom)));
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    evsm_req_t   r;
    logic [30:0] t;
    int          n, ph;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = blank_req();
    idle_pct = 0;
    mismatches = 0;
    handle_q = '0;
    for (int i = 0; i < NV; i++) begin
      v_on[i] = '0; v_addr[i] = '0; v_end[i] = '0; v_step[i] = '0; v_frac[i] = '0;
      v_tick[i] = '0; v_id[i] = '0; v_lg[i] = 0; v_rg[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: extreme bytes at store ends, extreme gains, saturation
    bank_base[0] = 16'hfffe;
    bank_len[0] = 1;
    pending_q.push_back(wr_req(16'hfffe, 8'd0));
    pending_q.push_back(wr_req(16'hffff, 8'd255));
    pending_q.push_back(wr_req(16'h0000, 8'd128));
    pending_q.push_back(blank_req());
    for (int k = 0; k < 8; k++) begin
      r = snd_req(0, 31'(k));
      r.mem_addr = 16'hfffe;
      // largest step ends at once, past the top of the store
      r.sound_length = (k == 0) ? 17'd0 : (k == 1) ? 17'd3 : 17'h1ffff;
      r.pitch_step = (k == 1) ? 18'h3ffff : 18'd0;
      r.volume = 4'hf;
      r.separation = (k[0]) ? 8'hff : 8'h00;
      r.exclusive = 1'b0;
      r.sound_id = 8'(k);
      pending_q.push_back(r);
    end
    pending_q.push_back(mix_req());
    r = snd_req(0, 31'h7fffffff);
    r.mem_addr = 16'hfffe; r.sound_length = 17'd1; r.exclusive = 1'b1; r.sound_id = 8'd3;
    pending_q.push_back(r);
    r.exclusive = 1'b0; r.tick = 31'd0;          // takes the lowest free voice
    pending_q.push_back(r);
    for (int k = 0; k < 4; k++) pending_q.push_back(mix_req());
    drain();

    // Random phases over idle patterns
    t = 31'd100;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 79 : (ph == 3) ? 25 : 0;
      for (int b = 0; b < 4; b++) fill_bank(b, 16'($urandom), $urandom_range(1, 24));
      n = 0;
      while (n < 260) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            t = t + 31'($urandom_range(3));
            pending_q.push_back(snd_req($urandom_range(3), t));
          end
          9: pending_q.push_back(blank_req());
          default: pending_q.push_back(mix_req());
        endcase
        n++;
      end
      drain();
    end
    finish_run();
  end

  // Report the verdict and stop
  task automatic finish_run();
    if (mismatches == 0 && expected_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  endtask

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYC_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end
endmodule

// File: files.f
rtl/core/evsm_pkg.sv
rtl/core/evsm_ram.sv
rtl/core/evsm_engine.sv
rtl/core/eight_voice_sample_mixer_top.sv
dv/tb.sv
